>>> hw/rtl/rmb_pkg.sv
`default_nettype none

package rmb_pkg;

    // Fixed-point constants of the weight arithmetic.
    localparam int unsigned WEIGHT_W   = 32;
    localparam int unsigned RATE_W     = 16;
    localparam int unsigned AGE_FRAC   = 12;
    localparam logic [31:0] AGE_ONE    = 32'h0001_0000;
    localparam logic [15:0] RATE_RESET = 16'd4116;

    // One input item.
    typedef struct packed {
        logic [11:0] pixel_address;
        logic [7:0]  sample_value;
        logic        frame_end;
    } t_in_item;

    // One result item.
    typedef struct packed {
        logic [11:0] out_address;
        logic [7:0]  background_value;
    } t_out_item;

    // Controller states.
    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOAD,
        ST_UPDATE,
        ST_FETCH,
        ST_UP,
        ST_DOWN,
        ST_DONE,
        ST_AGE_MUL,
        ST_AGE_SAT,
        ST_AGE_ADD
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;
        logic clear;
        logic load;
        logic update;
        logic up_step;
        logic down_enter;
        logic down_sub;
        logic down_step;
        logic store;
        logic out_load;
        logic age_mul;
        logic age_sat;
        logic age_add;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clear_done;
        logic addr_ok;
        logic last;
        logic up_cont;
        logic down_start;
        logic down_cont;
    } t_dp_sts;

endpackage

`default_nettype wire

>>> hw/rtl/running_median_background_unit.sv
// The median walks bin by bin, one histogram memory read a step, moving 0 to
// 256 / BIN_SIZE - 1 bins. A new item is accepted only once the previous one is done,
// and a result waits in ST_DONE while the output register is stalled; an item ending a
// frame adds the age update, and one with an address at or beyond PIXELS gives no result.
// Reset: synchronous, active low; then a clearing pass over PIXELS * 256 / BIN_SIZE
// histogram entries (131072 by default) zeroes the memories while input stays stalled.
`default_nettype none

module running_median_background_unit #(
    parameter int PIXELS   = 4096,
    parameter int BIN_SIZE = 8
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire rmb_pkg::t_in_item  i_in_item,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output rmb_pkg::t_out_item      o_out_item,
    input  wire logic               i_cfg_we,
    input  wire logic [15:0]        i_cfg_wdata
);
    import rmb_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;

    // Sequencer for clearing, the median walk and the age update.
    rmb_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (cmd),
        .i_sts       (sts)
    );

    // Memories, weights and arithmetic.
    rmb_dp #(
        .PIXELS   (PIXELS),
        .BIN_SIZE (BIN_SIZE)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_in_item   (i_in_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_out_item  (o_out_item)
    );

endmodule

`default_nettype wire

>>> hw/rtl/rmb_dp.sv
`default_nettype none

module rmb_dp #(
    parameter int PIXELS   = 4096,
    parameter int BIN_SIZE = 8
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire rmb_pkg::t_dp_cmd  i_cmd,
    output rmb_pkg::t_dp_sts       o_sts,
    input  wire rmb_pkg::t_in_item i_in_item,
    input  wire logic              i_cfg_we,
    input  wire logic [15:0]       i_cfg_wdata,
    output rmb_pkg::t_out_item     o_out_item
);
    import rmb_pkg::*;

    localparam int NBINS    = 256 / BIN_SIZE;
    localparam int HDEPTH   = PIXELS * NBINS;
    localparam int AW       = (PIXELS > 1) ? $clog2(PIXELS) : 1;
    localparam int HW       = (HDEPTH > 1) ? $clog2(HDEPTH) : 1;
    localparam int BW       = (NBINS > 1) ? $clog2(NBINS) : 1;
    localparam int CLR_LAST = HDEPTH - 1;
    localparam int BIN_LAST = NBINS - 1;

    // Saturating 32-bit addition of weights.
    function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

    // Value-to-bin table, worked out at elaboration; the top bin absorbs the remainder.
    logic [BW-1:0] bin_of [256];
    for (genvar g = 0; g < 256; g++) begin : g_bin_of
        assign bin_of[g] = BW'(((g / BIN_SIZE) > BIN_LAST) ? BIN_LAST
                                                          : (g / BIN_SIZE));
    end

    // Memories: histogram bins, below-median weight and median per pixel.
    logic [31:0] hist_mem   [HDEPTH];
    logic [31:0] below_mem  [PIXELS];
    logic [7:0]  median_mem [PIXELS];

    // Registers.
    logic [15:0]     r_aging_rate;
    logic [31:0]     r_age;
    logic [31:0]     r_total;
    logic [47:0]     r_prod;
    logic [HW-1:0]   r_clr;
    logic [11:0]     r_addr12;
    logic [AW-1:0]   r_pix;
    logic [HW-1:0]   r_base;
    logic [BW-1:0]   r_bin;
    logic [7:0]      r_val;
    logic            r_last;
    logic            r_addr_ok;
    logic [31:0]     r_below;
    logic [BW-1:0]   r_mb;
    logic [31:0]     r_hist_rd;
    logic [31:0]     r_below_rd;
    logic [7:0]      r_median_rd;
    t_out_item       r_out;

    // Combinational signals.
    logic [31:0]     addr_ext;
    logic [AW-1:0]   in_pix;
    logic            in_ok;
    logic [31:0]     half;
    logic [32:0]     sum_up;
    logic [31:0]     sub_down;
    logic [31:0]     below_new;
    logic [7:0]      bg_value;
    logic [35:0]     age_shift;
    logic [31:0]     age_new;
    logic [HW-1:0]   hist_raddr;
    logic            hist_we;
    logic [HW-1:0]   hist_waddr;
    logic [31:0]     hist_wdata;
    logic            pix_we;
    logic [AW-1:0]   pix_waddr;
    logic [31:0]     below_wdata;
    logic [7:0]      median_wdata;

    // Input address decode.
    assign addr_ext = 32'(i_in_item.pixel_address);
    assign in_pix   = addr_ext[AW-1:0];
    assign in_ok    = (addr_ext < 32'(PIXELS));

    // Walk arithmetic: one add and compare per step.
    assign half     = {1'b0, r_total[31:1]};
    assign sum_up   = {1'b0, r_below} + {1'b0, r_hist_rd};
    assign sub_down = (r_below > r_hist_rd) ? (r_below - r_hist_rd) : 32'd0;
    assign below_new = (r_val < r_median_rd) ? sat_add(r_below_rd, r_age) : r_below_rd;
    assign bg_value = 8'(32'(r_mb) * 32'(BIN_SIZE));

    // Age update: the shifted product saturates to 32 bits.
    assign age_shift = r_prod[47:AGE_FRAC];
    assign age_new   = (|age_shift[35:32]) ? 32'hFFFF_FFFF : age_shift[31:0];

    // Status to the controller.
    always_comb begin
        o_sts.clear_done = (r_clr == HW'(CLR_LAST));
        o_sts.addr_ok    = r_addr_ok;
        o_sts.last       = r_last;
        o_sts.up_cont    = (sum_up < {1'b0, half}) && (r_mb < BW'(BIN_LAST));
        o_sts.down_start = (r_below > half) && (r_mb != '0);
        o_sts.down_cont  = (sub_down > half) && (r_mb != '0);
    end

    // Histogram read address for the next cycle.
    always_comb begin
        hist_raddr = r_base + HW'(r_mb);
        if (i_cmd.load) begin
            hist_raddr = r_base + HW'(r_bin);
        end else if (i_cmd.up_step) begin
            hist_raddr = r_base + HW'(BW'(r_mb + 1'b1));
        end else if (i_cmd.down_enter || i_cmd.down_step) begin
            hist_raddr = r_base + HW'(BW'(r_mb - 1'b1));
        end
    end

    // Memory write ports: clearing pass, bin update and final store.
    always_comb begin
        hist_we      = i_cmd.clear || i_cmd.update;
        hist_waddr   = i_cmd.clear ? r_clr : (r_base + HW'(r_bin));
        hist_wdata   = i_cmd.clear ? 32'd0 : sat_add(r_hist_rd, r_age);
        pix_we       = (i_cmd.clear && (32'(r_clr) < 32'(PIXELS))) || i_cmd.store;
        pix_waddr    = i_cmd.clear ? r_clr[AW-1:0] : r_pix;
        below_wdata  = i_cmd.clear ? 32'd0 : r_below;
        median_wdata = i_cmd.clear ? 8'd0 : bg_value;
    end

    // Histogram memory.
    always_ff @(posedge i_clk) begin
        if (hist_we) begin
            hist_mem[hist_waddr] <= hist_wdata;
        end
        r_hist_rd <= hist_mem[hist_raddr];
    end

    // Per-pixel memories.
    always_ff @(posedge i_clk) begin
        if (pix_we) begin
            below_mem[pix_waddr]  <= below_wdata;
            median_mem[pix_waddr] <= median_wdata;
        end
        r_below_rd  <= below_mem[r_pix];
        r_median_rd <= median_mem[r_pix];
    end

    // Global weights, aging rate and clearing counter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_aging_rate <= RATE_RESET;
            r_age        <= AGE_ONE;
            r_total      <= AGE_ONE;
            r_clr        <= '0;
        end else begin
            if (i_cfg_we) begin
                r_aging_rate <= i_cfg_wdata;
            end
            if (i_cmd.clear && !o_sts.clear_done) begin
                r_clr <= r_clr + 1'b1;
            end
            if (i_cmd.age_sat) begin
                r_age <= age_new;
            end
            if (i_cmd.age_add) begin
                r_total <= sat_add(r_total, r_age);
            end
        end
    end

    // Item registers and the median walk.
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_addr12  <= i_in_item.pixel_address;
            r_pix     <= in_pix;
            r_base    <= HW'(32'(in_pix) * 32'(NBINS));
            r_bin     <= bin_of[i_in_item.sample_value];
            r_val     <= i_in_item.sample_value;
            r_last    <= i_in_item.frame_end;
            r_addr_ok <= in_ok;
        end
        if (i_cmd.update) begin
            r_below <= below_new;
            r_mb    <= bin_of[r_median_rd];
        end
        if (i_cmd.up_step) begin
            r_below <= sat_add(r_below, r_hist_rd);
            r_mb    <= BW'(r_mb + 1'b1);
        end
        if (i_cmd.down_sub) begin
            r_below <= sub_down;
        end
        if (i_cmd.down_enter || i_cmd.down_step) begin
            r_mb <= BW'(r_mb - 1'b1);
        end
        if (i_cmd.age_mul) begin
            r_prod <= 48'(r_age) * 48'(r_aging_rate);
        end
        if (i_cmd.out_load) begin
            r_out.out_address      <= r_addr12;
            r_out.background_value <= bg_value;
        end
    end

    assign o_out_item = r_out;

endmodule

`default_nettype wire

>>> hw/rtl/rmb_ctrl.sv
`default_nettype none

module rmb_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_stall,
    output logic                  o_out_valid,
    input  wire logic             i_out_stall,
    output rmb_pkg::t_dp_cmd      o_cmd,
    input  wire rmb_pkg::t_dp_sts i_sts
);
    import rmb_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   slot_free;

    // The output register can take a result when empty or being drained.
    assign slot_free = !r_out_valid || !i_out_stall;

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                if (i_sts.clear_done) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (i_in_valid) n_state = ST_LOAD;
            end
            ST_LOAD: begin
                if (i_sts.addr_ok) n_state = ST_UPDATE;
                else if (i_sts.last) n_state = ST_AGE_MUL;
                else n_state = ST_IDLE;
            end
            ST_UPDATE: n_state = ST_FETCH;
            ST_FETCH:  n_state = ST_UP;
            ST_UP: begin
                if (i_sts.up_cont) n_state = ST_UP;
                else if (i_sts.down_start) n_state = ST_DOWN;
                else n_state = ST_DONE;
            end
            ST_DOWN: begin
                if (!i_sts.down_cont) n_state = ST_DONE;
            end
            ST_DONE: begin
                if (slot_free) n_state = i_sts.last ? ST_AGE_MUL : ST_IDLE;
            end
            ST_AGE_MUL: n_state = ST_AGE_SAT;
            ST_AGE_SAT: n_state = ST_AGE_ADD;
            ST_AGE_ADD: n_state = ST_IDLE;
            default:    n_state = ST_CLEAR;
        endcase
    end

    // Commands and handshake outputs.
    always_comb begin
        o_cmd      = '0;
        o_in_stall = 1'b1;
        case (r_state)
            ST_CLEAR: o_cmd.clear = 1'b1;
            ST_IDLE: begin
                o_in_stall   = 1'b0;
                o_cmd.accept = i_in_valid;
            end
            ST_LOAD:   o_cmd.load = 1'b1;
            ST_UPDATE: o_cmd.update = 1'b1;
            ST_FETCH:  o_cmd = '0;
            ST_UP: begin
                o_cmd.up_step    = i_sts.up_cont;
                o_cmd.down_enter = !i_sts.up_cont && i_sts.down_start;
            end
            ST_DOWN: begin
                o_cmd.down_sub  = 1'b1;
                o_cmd.down_step = i_sts.down_cont;
            end
            ST_DONE: begin
                o_cmd.store    = slot_free;
                o_cmd.out_load = slot_free;
            end
            ST_AGE_MUL: o_cmd.age_mul = 1'b1;
            ST_AGE_SAT: o_cmd.age_sat = 1'b1;
            ST_AGE_ADD: o_cmd.age_add = 1'b1;
            default:    o_cmd = '0;
        endcase
    end

    // Output valid flag.
    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire
